// ===== rtl/qnu_pkg.sv =====
// ----------------------------------------------------------------------------
// qnu_pkg: shared constants for the quaternion normalize unit
// Default widths and the lane count used by the top level; qnu_merge uses the lane count.
// ----------------------------------------------------------------------------
`default_nettype none

package qnu_pkg;

    localparam int IN_WIDTH_DEF      = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int NUM_LANES         = 4;

endpackage

`default_nettype wire

// ===== rtl/qnu_lane.sv =====
// ----------------------------------------------------------------------------
// qnu_lane: per-component rounding search pipeline
// One stage per result bit. Each stage decides one bit of the rounded value
// c * 2^F / sqrt(S) with shift-and-add updates of (2m-1)^2 * S and (2m-1) * S.
// ----------------------------------------------------------------------------
`default_nettype none

module qnu_lane #(
    parameter int IN_WIDTH      = 16,
    parameter int OUT_FRAC_BITS = 14
) (
    input  wire logic                       clk,
    input  wire logic                       adv,
    input  wire logic [2*IN_WIDTH-2:0]      sq,
    input  wire logic [2*IN_WIDTH:0]        sum,
    input  wire logic                       neg,
    output logic      [OUT_FRAC_BITS:0]     mag_out,
    output logic                            neg_out
);

    localparam int W  = IN_WIDTH;
    localparam int F  = OUT_FRAC_BITS;
    localparam int SW = 2 * W + 1;
    localparam int PW = 2 * W + 2 * F + 5;
    localparam int NS = F + 1;

    logic signed [PW-1:0] p_reg   [NS];
    logic signed [PW-1:0] q_reg   [NS];
    logic signed [PW-1:0] rhs_reg [NS];
    logic        [SW-1:0] s_reg   [NS];
    logic        [F:0]    m_reg   [NS];
    logic                 neg_reg [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam int B = F - k;

        logic signed [PW-1:0] p_in;
        logic signed [PW-1:0] q_in;
        logic signed [PW-1:0] r_in;
        logic signed [PW-1:0] s_ext;
        logic signed [PW-1:0] cand;
        logic        [SW-1:0] s_in;
        logic        [F:0]    m_in;
        logic                 n_in;
        logic                 take;

        if (k == 0) begin : g_first
            assign s_in = sum;
            assign p_in = $signed({{(PW-SW){1'b0}}, sum});
            assign q_in = -$signed({{(PW-SW){1'b0}}, sum});
            assign r_in = $signed({{(PW-(2*W-1)){1'b0}}, sq}) <<< (2 * F + 2);
            assign m_in = '0;
            assign n_in = neg;
        end
        else begin : g_next
            assign s_in = s_reg[k-1];
            assign p_in = p_reg[k-1];
            assign q_in = q_reg[k-1];
            assign r_in = rhs_reg[k-1];
            assign m_in = m_reg[k-1];
            assign n_in = neg_reg[k-1];
        end

        assign s_ext = $signed({{(PW-SW){1'b0}}, s_in});
        assign cand  = p_in + (q_in <<< (B + 2)) + (s_ext <<< (2 * B + 2));
        assign take  = !m_in[F] && (cand <= r_in);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s_reg[k]   <= s_in;
                rhs_reg[k] <= r_in;
                neg_reg[k] <= n_in;
                if (take)
                begin
                    p_reg[k] <= cand;
                    q_reg[k] <= q_in + (s_ext <<< (B + 1));
                    m_reg[k] <= m_in | ((F+1)'(1) << B);
                end
                else
                begin
                    p_reg[k] <= p_in;
                    q_reg[k] <= q_in;
                    m_reg[k] <= m_in;
                end
            end
        end
    end

    assign mag_out = m_reg[NS-1];
    assign neg_out = neg_reg[NS-1];

endmodule

`default_nettype wire

// ===== rtl/qnu_merge.sv =====
// ----------------------------------------------------------------------------
// qnu_merge: output stage
// Apply signs, force zero for a zero quaternion and hold the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module qnu_merge #(
    parameter int OUT_FRAC_BITS = 14
) (
    input  wire logic                                                clk,
    input  wire logic                                                adv,
    input  wire logic [qnu_pkg::NUM_LANES-1:0][OUT_FRAC_BITS:0]      mag,
    input  wire logic [qnu_pkg::NUM_LANES-1:0]                       neg,
    input  wire logic                                                zero,
    output logic      [qnu_pkg::NUM_LANES-1:0][OUT_FRAC_BITS+1:0]    res,
    output logic                                                     res_zero
);

    import qnu_pkg::*;

    localparam int OW = OUT_FRAC_BITS + 2;

    logic [NUM_LANES-1:0][OW-1:0] res_reg;
    logic [NUM_LANES-1:0][OW-1:0] res_next;
    logic                         zero_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (zero)
                res_next[i] = '0;
            else if (neg[i])
                res_next[i] = -{1'b0, mag[i]};
            else
                res_next[i] = {1'b0, mag[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg  <= res_next;
            zero_reg <= zero;
        end
    end

    assign res      = res_reg;
    assign res_zero = zero_reg;

endmodule

`default_nettype wire

// ===== rtl/quaternion_normalize_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_normalize_unit: unit quaternion from a Q4.12 quaternion
// Input stream s_*: one quaternion per transfer, tdata = {z, y, x, w}.
// Output stream m_*: the normalized quaternion in Q1.14, each component
// rounded to nearest, tdata = {z, y, x, w}; tuser flags an all-zero input,
// in which case every component is zero.
// Pipeline: a register for the squares, one for their sum, one search stage
// per result bit in each of the four parallel lanes, and the output register.
// Throughput is one transfer per cycle while the receiver does not stall; every
// stage is a register, so items follow back to back without a gap.
// When a finished result waits in the output register and the receiver stalls,
// the whole pipeline holds and s_tready drops.
// Reset clears every valid bit; the block then takes input at once.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_normalize_unit #(
    parameter int IN_WIDTH      = qnu_pkg::IN_WIDTH_DEF,
    parameter int OUT_FRAC_BITS = qnu_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic                                                  clk,
    input  wire logic                                                  rst_n,
    input  wire logic                                                  s_tvalid,
    output logic                                                       s_tready,
    // in_w, in_x, in_y, in_z from bit 0 up, zero padded to whole bytes
    input  wire logic [((qnu_pkg::NUM_LANES*IN_WIDTH+7)/8)*8-1:0]      s_tdata,
    output logic                                                       m_tvalid,
    input  wire logic                                                  m_tready,
    // out_w, out_x, out_y, out_z from bit 0 up, zero padded to whole bytes
    output logic [((qnu_pkg::NUM_LANES*(OUT_FRAC_BITS+2)+7)/8)*8-1:0]  m_tdata,
    // zero_input
    output logic                                                       m_tuser
);

    import qnu_pkg::*;

    localparam int W      = IN_WIDTH;
    localparam int F      = OUT_FRAC_BITS;
    localparam int OW     = F + 2;
    localparam int SW     = 2 * W + 1;
    localparam int NS     = F + 1;
    localparam int LAT    = F + 4;
    localparam int OUT_DW = ((NUM_LANES * OW + 7) / 8) * 8;

    logic                                 adv;
    logic [LAT-1:0]                       vld_reg;
    logic [NUM_LANES-1:0][2*W-2:0]        sq1_reg;
    logic [NUM_LANES-1:0]                 neg1_reg;
    logic [NUM_LANES-1:0][2*W-2:0]        sq2_reg;
    logic [NUM_LANES-1:0]                 neg2_reg;
    logic [SW-1:0]                        sum2_reg;
    logic [SW-1:0]                        sum_next;
    logic                                 zero2_reg;
    logic [NS-1:0]                        zero_dly_reg;
    logic [NUM_LANES-1:0][F:0]            lane_mag;
    logic [NUM_LANES-1:0]                 lane_neg;
    logic [NUM_LANES-1:0][OW-1:0]         res;
    logic                                 res_zero;

    assign adv      = !vld_reg[LAT-1] || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_sq
        logic signed [W-1:0]   comp;
        logic signed [2*W-1:0] prod;

        assign comp = $signed(s_tdata[i*W +: W]);
        assign prod = comp * comp;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq1_reg[i]  <= prod[2*W-2:0];
                neg1_reg[i] <= comp[W-1];
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NUM_LANES; i++)
            sum_next = sum_next + SW'(sq1_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq2_reg      <= sq1_reg;
            neg2_reg     <= neg1_reg;
            sum2_reg     <= sum_next;
            zero2_reg    <= (sum_next == '0);
            zero_dly_reg <= {zero_dly_reg[NS-2:0], zero2_reg};
        end
    end

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        qnu_lane #(
            .IN_WIDTH      (W),
            .OUT_FRAC_BITS (F)
        ) u_lane (
            .clk     (clk),
            .adv     (adv),
            .sq      (sq2_reg[i]),
            .sum     (sum2_reg),
            .neg     (neg2_reg[i]),
            .mag_out (lane_mag[i]),
            .neg_out (lane_neg[i])
        );
    end

    qnu_merge #(
        .OUT_FRAC_BITS (F)
    ) u_merge (
        .clk      (clk),
        .adv      (adv),
        .mag      (lane_mag),
        .neg      (lane_neg),
        .zero     (zero_dly_reg[NS-1]),
        .res      (res),
        .res_zero (res_zero)
    );

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = OUT_DW'(res);
    assign m_tuser  = res_zero;

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> res == '0)
        else $error("zero input with nonzero result");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(res[0]) <= $signed(OW'(1) << F)
                  && $signed(res[0]) >= -$signed(OW'(1) << F))
        else $error("result out of unit range");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

`default_nettype wire
